// ===== rtl/tlbpt_pkg.sv =====
`default_nettype none
package tlbpt_pkg;

   // Field widths of the request and response words.
   localparam int VA_W  = 16;
   localparam int PA_W  = 16;
   localparam int CNT_W = 32;

   // Sizes of the translation structures.
   localparam int TLB_ENTRIES = 16;
   localparam int PAGE_COUNT  = 256;
   localparam int PAGE_BYTES  = 256;

   localparam int OFFSET_W  = $clog2(PAGE_BYTES);
   localparam int PAGE_W    = $clog2(PAGE_COUNT);
   localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
   localparam int TAG_W     = 8;
   localparam int FRAME_W   = 8;
   localparam int NFF_W     = 9;

   localparam logic [NFF_W-1:0]     NFF_MAX  = '1;
   localparam logic [CNT_W-1:0]     CNT_MAX  = '1;
   localparam logic [TLB_IDX_W-1:0] TLB_LAST = TLB_IDX_W'(TLB_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_FETCH
   } state_type;

   typedef struct packed {
      logic load_va;
      logic pt_read;
      logic hit_done;
      logic miss_done;
   } cmd_type;

   typedef struct packed {
      logic tlb_hit;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/tlbpt_ram.sv =====
`default_nettype none
module tlbpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/tlbpt_ctrl.sv =====
`default_nettype none
module tlbpt_ctrl
   import tlbpt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (!status.tlb_hit) begin
               state_in = ST_FETCH;
            end else if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      cmd.load_va   = 1'b0;
      cmd.pt_read   = 1'b0;
      cmd.hit_done  = 1'b0;
      cmd.miss_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.load_va = req_valid;
         end
         ST_LOOKUP: begin
            cmd.pt_read  = !status.tlb_hit;
            cmd.hit_done = status.tlb_hit && status.out_free;
         end
         ST_FETCH: begin
            cmd.miss_done = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/tlbpt_datapath.sv =====
`default_nettype none
module tlbpt_datapath
   import tlbpt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [VA_W-1:0]   req_virtual_address,
   input  wire cmd_type           cmd,
   output status_type             status,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [PA_W-1:0]   rsp_physical_address,
   output logic                   rsp_tlb_hit,
   output logic                   rsp_page_fault,
   output logic      [CNT_W-1:0]  rsp_reference_count,
   output logic      [CNT_W-1:0]  rsp_hit_count,
   output logic      [CNT_W-1:0]  rsp_fault_count
);

   logic [VA_W-1:0]      va_ff;
   logic [TAG_W-1:0]     tlb_page_ff  [TLB_ENTRIES];
   logic [FRAME_W-1:0]   tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_valid_ff;
   logic [TLB_IDX_W-1:0] fifo_ptr_ff;
   logic [PAGE_COUNT-1:0] page_valid_ff;
   logic [NFF_W-1:0]     nff_ff;
   logic [CNT_W-1:0]     ref_cnt_ff;
   logic [CNT_W-1:0]     hit_cnt_ff;
   logic [CNT_W-1:0]     fault_cnt_ff;
   logic                 rsp_valid_ff;
   logic [PA_W-1:0]      rsp_pa_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_fault_ff;
   logic [CNT_W-1:0]     rsp_ref_ff;
   logic [CNT_W-1:0]     rsp_hits_ff;
   logic [CNT_W-1:0]     rsp_faults_ff;

   logic [PAGE_W-1:0]    page_idx;
   logic [OFFSET_W-1:0]  offset;
   logic [TAG_W-1:0]     tag;
   logic                 hit;
   logic [FRAME_W-1:0]   hit_frame;
   logic [FRAME_W-1:0]   pt_frame;
   logic [FRAME_W-1:0]   new_frame;
   logic                 fault;
   logic [FRAME_W-1:0]   frame;
   logic                 out_load;
   logic [CNT_W-1:0]     ref_cnt_in;
   logic [CNT_W-1:0]     hit_cnt_in;
   logic [CNT_W-1:0]     fault_cnt_in;
   logic [NFF_W-1:0]     nff_in;

   assign page_idx  = PAGE_W'(va_ff >> OFFSET_W);
   assign offset    = va_ff[OFFSET_W-1:0];
   assign tag       = TAG_W'(page_idx);
   assign new_frame = nff_ff[FRAME_W-1:0];

   // Walk from the top so that the lowest matching entry has the last word.
   always_comb begin
      hit       = 1'b0;
      hit_frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && (tlb_page_ff[i] == tag)) begin
            hit       = 1'b1;
            hit_frame = tlb_frame_ff[i];
         end
      end
   end

   tlbpt_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (PAGE_COUNT)
   ) u_page_table (
      .clock   (clock),
      .wr_en   (cmd.miss_done && fault),
      .wr_addr (page_idx),
      .wr_data (new_frame),
      .rd_en   (cmd.pt_read),
      .rd_addr (page_idx),
      .rd_data (pt_frame)
   );

   // The page valid bit stands in for the cleared page table contents.
   assign fault    = !page_valid_ff[page_idx];
   assign frame    = cmd.hit_done ? hit_frame : (fault ? new_frame : pt_frame);
   assign out_load = cmd.hit_done || cmd.miss_done;

   assign status.tlb_hit  = hit;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ref_cnt_in   = ref_cnt_ff;
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      nff_in       = nff_ff;
      if (out_load && (ref_cnt_ff != CNT_MAX)) ref_cnt_in = ref_cnt_ff + 1'b1;
      if (cmd.hit_done && (hit_cnt_ff != CNT_MAX)) hit_cnt_in = hit_cnt_ff + 1'b1;
      if (cmd.miss_done && fault) begin
         if (fault_cnt_ff != CNT_MAX) fault_cnt_in = fault_cnt_ff + 1'b1;
         if (nff_ff != NFF_MAX) nff_in = nff_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff  <= '0;
         fifo_ptr_ff   <= '0;
         page_valid_ff <= '0;
         nff_ff        <= '0;
         ref_cnt_ff    <= '0;
         hit_cnt_ff    <= '0;
         fault_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         nff_ff       <= nff_in;
         ref_cnt_ff   <= ref_cnt_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         if (cmd.miss_done) begin
            page_valid_ff[page_idx] <= 1'b1;
            tlb_valid_ff[fifo_ptr_ff] <= 1'b1;
            fifo_ptr_ff <= (fifo_ptr_ff == TLB_LAST) ? '0 : fifo_ptr_ff + 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_va) begin
         va_ff <= req_virtual_address;
      end
      if (cmd.miss_done) begin
         tlb_page_ff[fifo_ptr_ff]  <= tag;
         tlb_frame_ff[fifo_ptr_ff] <= frame;
      end
      if (out_load) begin
         rsp_pa_ff     <= PA_W'({frame, offset});
         rsp_hit_ff    <= cmd.hit_done;
         rsp_fault_ff  <= cmd.miss_done && fault;
         rsp_ref_ff    <= ref_cnt_in;
         rsp_hits_ff   <= hit_cnt_in;
         rsp_faults_ff <= fault_cnt_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_reference_count  = rsp_ref_ff;
   assign rsp_hit_count        = rsp_hits_ff;
   assign rsp_fault_count      = rsp_faults_ff;

endmodule
`default_nettype wire

// ===== rtl/tlb_page_table_translator_top.sv =====
// A word is registered in IDLE; a TLB hit then loads the response register from
// LOOKUP and a TLB miss from FETCH, the extra state being the registered read of
// the page-table memory; both wait while the response register is held. No new
// word is taken until the last is in the response register, which lets the next
// word in while a result still waits. Reset clears the TLB and page valid bits,
// the FIFO pointer, the free-frame counter and all counts at once, with no sweep.
`default_nettype none
module tlb_page_table_translator_top
   import tlbpt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [VA_W-1:0]   req_virtual_address,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [PA_W-1:0]   rsp_physical_address,
   output logic                   rsp_tlb_hit,
   output logic                   rsp_page_fault,
   output logic      [CNT_W-1:0]  rsp_reference_count,
   output logic      [CNT_W-1:0]  rsp_hit_count,
   output logic      [CNT_W-1:0]  rsp_fault_count
);

   cmd_type    cmd;
   status_type status;

   tlbpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tlbpt_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_virtual_address  (req_virtual_address),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_reference_count  (rsp_reference_count),
      .rsp_hit_count        (rsp_hit_count),
      .rsp_fault_count      (rsp_fault_count)
   );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import tlbpt_pkg::*;

   localparam int RANDOM_WORDS   = 830;
   localparam int PHASE_COUNT    = 3;
   localparam int HOLDOFF_CYCLES = 150;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DIRECTED_ROWS  = 21;

   typedef struct packed {
      logic [PA_W-1:0]  physical_address;
      logic             tlb_hit;
      logic             page_fault;
      logic [CNT_W-1:0] reference_count;
      logic [CNT_W-1:0] hit_count;
      logic [CNT_W-1:0] fault_count;
   } xlate_type;

   typedef struct packed {
      logic [VA_W-1:0] virtual_address;
      logic            typed;
      xlate_type       result;
   } dir_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [VA_W-1:0]   req_virtual_address;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [PA_W-1:0]   rsp_physical_address;
   logic              rsp_tlb_hit;
   logic              rsp_page_fault;
   logic [CNT_W-1:0]  rsp_reference_count;
   logic [CNT_W-1:0]  rsp_hit_count;
   logic [CNT_W-1:0]  rsp_fault_count;

   // Shadow copy of the translation state.
   logic [TAG_W-1:0]     shadow_tlb_tag [TLB_ENTRIES];
   logic [FRAME_W-1:0]   shadow_tlb_frame [TLB_ENTRIES];
   logic                 shadow_tlb_live [TLB_ENTRIES];
   logic [TLB_IDX_W-1:0] shadow_fifo_slot;
   logic [FRAME_W-1:0]   shadow_pt_frame [PAGE_COUNT];
   logic                 shadow_pt_live [PAGE_COUNT];
   logic [NFF_W-1:0]     shadow_free_frame;
   logic [CNT_W-1:0]     shadow_references;
   logic [CNT_W-1:0]     shadow_hits;
   logic [CNT_W-1:0]     shadow_faults;

   xlate_type   pending_translations [$];
   xlate_type   oldest_translation;
   dir_row_type directed_rows [DIRECTED_ROWS];
   int       mismatch_count = 0;
   int       idle_cycles = 0;
   int       req_idle_pct = 12;
   int       rsp_idle_pct = 70;
   bit       holdoff_pending = 1'b0;
   logic [7:0] hot_pages [8];
   logic [7:0] warm_pages [32];

   tlb_page_table_translator_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_reference_count  (rsp_reference_count),
      .rsp_hit_count        (rsp_hit_count),
      .rsp_fault_count      (rsp_fault_count)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic xlate_type translate_address(input logic [VA_W-1:0] va);
      int            page;
      int            offset;
      logic [TAG_W-1:0]   tag;
      logic [FRAME_W-1:0] frame;
      xlate_type     res;
      page   = (int'(va) / PAGE_BYTES) % PAGE_COUNT;
      offset = int'(va) % PAGE_BYTES;
      tag    = TAG_W'(page);
      frame  = '0;
      res    = '0;
      // The lowest-numbered matching entry wins when several match.
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (shadow_tlb_live[i] && shadow_tlb_tag[i] == tag) begin
            frame = shadow_tlb_frame[i];
            res.tlb_hit = 1'b1;
         end
      end
      if (!res.tlb_hit) begin
         if (!shadow_pt_live[page]) begin
            shadow_pt_frame[page] = shadow_free_frame[FRAME_W-1:0];
            shadow_pt_live[page]  = 1'b1;
            if (shadow_free_frame != NFF_MAX) shadow_free_frame++;
            res.page_fault = 1'b1;
            if (shadow_faults != CNT_MAX) shadow_faults++;
         end
         frame = shadow_pt_frame[page];
         shadow_tlb_tag[shadow_fifo_slot]   = tag;
         shadow_tlb_frame[shadow_fifo_slot] = frame;
         shadow_tlb_live[shadow_fifo_slot]  = 1'b1;
         shadow_fifo_slot = (shadow_fifo_slot == TLB_LAST) ? '0 : shadow_fifo_slot + 1'b1;
      end else if (shadow_hits != CNT_MAX) begin
         shadow_hits++;
      end
      if (shadow_references != CNT_MAX) shadow_references++;
      res.physical_address = PA_W'(int'(frame) * PAGE_BYTES + offset);
      res.reference_count  = shadow_references;
      res.hit_count        = shadow_hits;
      res.fault_count      = shadow_faults;
      return res;
   endfunction

   function void check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Offer one word, wait for it to be taken, then record what it must produce.
   task automatic send_word(input logic [VA_W-1:0] va, input logic typed,
                            input xlate_type typed_result);
      xlate_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_virtual_address <= va;
      do @(posedge clock); while (req_stall);
      predicted = translate_address(va);
      pending_translations.push_back(typed ? typed_result : predicted);
   endtask

   task automatic wait_for_drain();
      while (pending_translations.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_pending) begin
            holdoff_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES - 1) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_translations.size() == 0) begin
            $error("response word arrived with no translation pending");
            mismatch_count++;
         end else begin
            oldest_translation = pending_translations.pop_front();
            check_field("physical_address", 32'(oldest_translation.physical_address),
                        32'(rsp_physical_address));
            check_field("tlb_hit", 32'(oldest_translation.tlb_hit), 32'(rsp_tlb_hit));
            check_field("page_fault", 32'(oldest_translation.page_fault),
                        32'(rsp_page_fault));
            check_field("reference_count", oldest_translation.reference_count,
                        rsp_reference_count);
            check_field("hit_count", oldest_translation.hit_count, rsp_hit_count);
            check_field("fault_count", oldest_translation.fault_count, rsp_fault_count);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tlb_page_table_translator_top regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int         pick;
      logic [7:0] page;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_virtual_address = '0;

      for (int i = 0; i < TLB_ENTRIES; i++) begin
         shadow_tlb_tag[i]   = '0;
         shadow_tlb_frame[i] = '0;
         shadow_tlb_live[i]  = 1'b0;
      end
      for (int i = 0; i < PAGE_COUNT; i++) begin
         shadow_pt_frame[i] = '0;
         shadow_pt_live[i]  = 1'b0;
      end
      shadow_fifo_slot  = '0;
      shadow_free_frame = '0;
      shadow_references = '0;
      shadow_hits       = '0;
      shadow_faults     = '0;
      foreach (hot_pages[i]) hot_pages[i] = 8'($urandom);
      foreach (warm_pages[i]) warm_pages[i] = 8'($urandom);

      // The first rows allocate frames in order, so their results are known.
      directed_rows[0]  = '{16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1, 32'd1, 32'd0, 32'd1}};
      directed_rows[1]  = '{16'hFFFF, 1'b1, '{16'h01FF, 1'b0, 1'b1, 32'd2, 32'd0, 32'd2}};
      directed_rows[2]  = '{16'h00FF, 1'b1, '{16'h00FF, 1'b1, 1'b0, 32'd3, 32'd1, 32'd2}};
      directed_rows[3]  = '{16'hFF00, 1'b1, '{16'h0100, 1'b1, 1'b0, 32'd4, 32'd2, 32'd2}};
      directed_rows[4]  = '{16'h5555, 1'b1, '{16'h0255, 1'b0, 1'b1, 32'd5, 32'd2, 32'd3}};
      directed_rows[5]  = '{16'hAAAA, 1'b1, '{16'h03AA, 1'b0, 1'b1, 32'd6, 32'd2, 32'd4}};
      // Fill the remaining TLB slots, then wrap the FIFO pointer.
      directed_rows[6]  = '{16'h0101, 1'b0, '0};
      directed_rows[7]  = '{16'h0210, 1'b0, '0};
      directed_rows[8]  = '{16'h0320, 1'b0, '0};
      directed_rows[9]  = '{16'h0430, 1'b0, '0};
      directed_rows[10] = '{16'h0540, 1'b0, '0};
      directed_rows[11] = '{16'h0650, 1'b0, '0};
      directed_rows[12] = '{16'h0760, 1'b0, '0};
      directed_rows[13] = '{16'h0870, 1'b0, '0};
      directed_rows[14] = '{16'h0980, 1'b0, '0};
      directed_rows[15] = '{16'h0A90, 1'b0, '0};
      directed_rows[16] = '{16'h0BA0, 1'b0, '0};
      directed_rows[17] = '{16'h0CB0, 1'b0, '0};
      directed_rows[18] = '{16'h0DC0, 1'b0, '0};
      // Evicted pages come back as TLB misses that find the page table filled.
      directed_rows[19] = '{16'h0080, 1'b0, '0};
      directed_rows[20] = '{16'hFF7F, 1'b0, '0};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_word(directed_rows[r].virtual_address, directed_rows[r].typed,
                   directed_rows[r].result);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         req_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 70 : 0;
         rsp_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 12 : 0;
         // With no sender gaps, a long receiver hold-off backs the block up.
         if (phase == 2) holdoff_pending = 1'b1;
         for (int n = 0; n < RANDOM_WORDS / PHASE_COUNT; n++) begin
            pick = $urandom_range(99);
            if ($urandom_range(19) == 0) hot_pages[$urandom_range(7)] = 8'($urandom);
            if (pick < 60) begin
               page = hot_pages[$urandom_range(7)];
            end else if (pick < 85) begin
               page = warm_pages[$urandom_range(31)];
            end else begin
               page = 8'($urandom);
            end
            send_word({page, 8'($urandom)}, 1'b0, '0);
         end
         @(negedge clock);
         req_valid <= 1'b0;
         wait_for_drain();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_translations.size() == 0) begin
         $display("tlb_page_table_translator_top regression: pass");
      end else begin
         $display("tlb_page_table_translator_top regression: fail");
      end
      $finish;
   end

endmodule
